// ===== rtl/hxs_pkg.sv =====
// Shared types, constants and small arithmetic helpers for the hex spiral index block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hxs_pkg;

  // Fixed field widths of the external interface.
  localparam int RC_W   = 9;
  localparam int IDX_W  = 20;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Reset value of the ring count register.
  localparam logic [RC_W-1:0] RC_RESET = 9'd4;

  // Register indexes on the configuration port (paddr[2] selects the word).
  localparam logic CFG_IDX_RING_COUNT = 1'b0;

  // Side of a ring, in walk order starting from cell (0, -k).
  typedef enum logic [2:0] {
    SIDE_0 = 3'd0,
    SIDE_1 = 3'd1,
    SIDE_2 = 3'd2,
    SIDE_3 = 3'd3,
    SIDE_4 = 3'd4,
    SIDE_5 = 3'd5
  } side_t;

  // Addition of two residues, where a is at most 2 and b at most 3.
  function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    return sum[1:0];
  endfunction

  // Residue modulo three of an unsigned 16-bit value: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] acc;
    logic [2:0] acc2;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + 5'(v[2*i +: 2]);
    end
    acc2 = 3'(acc[1:0]) + 3'(acc[3:2]) + 3'(acc[4]);
    if (acc2 >= 3'd6) begin
      acc2 = acc2 - 3'd6;
    end else if (acc2 >= 3'd3) begin
      acc2 = acc2 - 3'd3;
    end
    return acc2[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hxs_cfg.sv =====
// APB-style configuration register file: holds the ring count.
// Depends on hxs_pkg for widths, reset value and register indexes.
`default_nettype none

module hxs_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hxs_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [hxs_pkg::CFG_DW-1:0]  pwdata,
  output logic      [hxs_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [hxs_pkg::RC_W-1:0]    ring_count
);
  import hxs_pkg::*;

  logic [RC_W-1:0] ring_count_r;
  logic            wr_en;
  logic            sel_ring;

  // Word select and write strobe for the access phase.
  assign sel_ring = (paddr[2] == CFG_IDX_RING_COUNT);
  assign wr_en    = psel & penable & pwrite & pready;
  assign pready   = 1'b1;

  // Ring count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= RC_RESET;
    end else if (wr_en && sel_ring) begin
      ring_count_r <= pwdata[RC_W-1:0];
    end
  end

  // Read back; the unused word reads as zero.
  assign prdata     = sel_ring ? CFG_DW'(ring_count_r) : '0;
  assign ring_count = ring_count_r;

endmodule

`default_nettype wire

// ===== rtl/hxs_dist.sv =====
// First two pipeline stages: cube coordinates, magnitudes, hex distance, grid check, color.
// Depends on hxs_pkg for the residue helpers and the ring count width.
`default_nettype none

module hxs_dist #(
  parameter int COORD_BITS = 11,
  parameter int MAX_RINGS  = 511
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic signed [COORD_BITS-1:0]  in_q,
  input  wire logic signed [COORD_BITS-1:0]  in_r,
  input  wire logic [hxs_pkg::RC_W-1:0]      ring_count,
  output logic                               v2,
  output logic signed [COORD_BITS+1:0]       q2,
  output logic signed [COORD_BITS+1:0]       r2,
  output logic signed [COORD_BITS+1:0]       s2,
  output logic [COORD_BITS:0]                k2,
  output logic                               inside2,
  output logic [COORD_BITS-1:0]              dist2,
  output logic [1:0]                         color2
);
  import hxs_pkg::*;

  localparam int W  = COORD_BITS + 2;
  localparam int KW = COORD_BITS + 1;
  localparam int RW = $clog2(MAX_RINGS + 1);
  localparam int CW = (RW > RC_W) ? RW : RC_W;
  localparam int LW = (KW > CW) ? KW : CW;
  localparam logic [CW-1:0] MAX_LIM = CW'(MAX_RINGS);
  // Residue that a negative value needs on top of its raw bit pattern.
  localparam logic [1:0] WRAP_CORR = ((COORD_BITS % 2) == 0) ? 2'd2 : 2'd1;

  function automatic logic [KW-1:0] abs_w(input logic signed [W-1:0] x);
    logic signed [W-1:0] m;
    m = x[W-1] ? -x : x;
    return m[KW-1:0];
  endfunction

  // Stage 1 registers.
  logic                v1_r;
  logic signed [W-1:0] q1_r, r1_r, s1_r;
  logic [KW-1:0]       aq1_r, ar1_r, as1_r;
  logic [1:0]          qm1_r, rm1_r;

  logic signed [W-1:0] q_ext, r_ext, s_ext;
  logic [1:0]          qm_raw, rm_raw, qm_nxt, rm_nxt;

  // Stage 1: extend, form s = -q - r, magnitudes and residues of q and r.
  always_comb begin
    q_ext  = {{2{in_q[COORD_BITS-1]}}, in_q};
    r_ext  = {{2{in_r[COORD_BITS-1]}}, in_r};
    s_ext  = -q_ext - r_ext;
    qm_raw = mod3_16(16'($unsigned(in_q)));
    rm_raw = mod3_16(16'($unsigned(in_r)));
    qm_nxt = in_q[COORD_BITS-1] ? mod3_add(qm_raw, WRAP_CORR) : qm_raw;
    rm_nxt = in_r[COORD_BITS-1] ? mod3_add(rm_raw, WRAP_CORR) : rm_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    q1_r  <= q_ext;
    r1_r  <= r_ext;
    s1_r  <= s_ext;
    aq1_r <= abs_w(q_ext);
    ar1_r <= abs_w(r_ext);
    as1_r <= abs_w(s_ext);
    qm1_r <= qm_nxt;
    rm1_r <= rm_nxt;
  end

  // Stage 2: distance is the largest magnitude; compare it with the clamped ring count.
  logic [KW-1:0]         k_qr, k_nxt;
  logic [CW-1:0]         lim;
  logic                  inside_nxt;
  logic [COORD_BITS-1:0] dist_nxt;
  logic [1:0]            color_nxt;

  always_comb begin
    k_qr       = (ar1_r > aq1_r) ? ar1_r : aq1_r;
    k_nxt      = (as1_r > k_qr) ? as1_r : k_qr;
    lim        = (CW'(ring_count) > MAX_LIM) ? MAX_LIM : CW'(ring_count);
    inside_nxt = (LW'(k_nxt) <= LW'(lim));
    dist_nxt   = k_nxt[KW-1] ? '1 : k_nxt[COORD_BITS-1:0];
    color_nxt  = mod3_add(qm1_r, 2'd3 - rm1_r);
  end

  logic                  v2_r;
  logic signed [W-1:0]   q2_r, r2_r, s2_r;
  logic [KW-1:0]         k2_r;
  logic                  inside2_r;
  logic [COORD_BITS-1:0] dist2_r;
  logic [1:0]            color2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    q2_r      <= q1_r;
    r2_r      <= r1_r;
    s2_r      <= s1_r;
    k2_r      <= k_nxt;
    inside2_r <= inside_nxt;
    dist2_r   <= dist_nxt;
    color2_r  <= color_nxt;
  end

  assign v2      = v2_r;
  assign q2      = q2_r;
  assign r2      = r2_r;
  assign s2      = s2_r;
  assign k2      = k2_r;
  assign inside2 = inside2_r;
  assign dist2   = dist2_r;
  assign color2  = color2_r;

endmodule

`default_nettype wire

// ===== rtl/hxs_side.sv =====
// Third pipeline stage: picks the ring side and the step along it, and forms the
// ring base product k*(k-1) and the side offset side*k. Depends on hxs_pkg.
`default_nettype none

module hxs_side #(
  parameter int COORD_BITS = 11,
  parameter int MAX_RINGS  = 511
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 v2,
  input  wire logic signed [COORD_BITS+1:0]         q2,
  input  wire logic signed [COORD_BITS+1:0]         r2,
  input  wire logic signed [COORD_BITS+1:0]         s2,
  input  wire logic [COORD_BITS:0]                  k2,
  input  wire logic                                 inside2,
  input  wire logic [COORD_BITS-1:0]                dist2,
  input  wire logic [1:0]                           color2,
  output logic                                      v3,
  output logic                                      nz3,
  output logic                                      inside3,
  output logic [2*$clog2(MAX_RINGS+1)-1:0]          kk3,
  output logic [$clog2(MAX_RINGS+1)+2:0]            sk3,
  output logic [$clog2(MAX_RINGS+1)-1:0]            step3,
  output logic [COORD_BITS-1:0]                     dist3,
  output logic [1:0]                                color3
);
  import hxs_pkg::*;

  localparam int W  = COORD_BITS + 2;
  localparam int RW = $clog2(MAX_RINGS + 1);
  localparam int KW = 2 * RW;
  localparam int SW = RW + 3;

  logic signed [W-1:0] ks, nk, step_w;
  side_t               side;
  logic [RW-1:0]       km, km_m1;
  logic [KW-1:0]       kk_nxt;
  logic [SW-1:0]       sk_nxt;

  // Side selection follows the walk order; the last side takes what is left.
  always_comb begin
    ks = $signed({1'b0, k2});
    nk = -ks;
    if (r2 == nk && q2 >= 0 && q2 < ks) begin
      side   = SIDE_0;
      step_w = q2;
    end else if (q2 == ks && r2 < 0) begin
      side   = SIDE_1;
      step_w = r2 + ks;
    end else if (s2 == nk && r2 >= 0 && r2 < ks) begin
      side   = SIDE_2;
      step_w = r2;
    end else if (r2 == ks && q2 <= 0 && q2 > nk) begin
      side   = SIDE_3;
      step_w = -q2;
    end else if (q2 == nk && r2 > 0) begin
      side   = SIDE_4;
      step_w = ks - r2;
    end else begin
      side   = SIDE_5;
      step_w = q2 + ks;
    end
  end

  // Ring base and side offset; only meaningful when the cell is inside, where k fits RW bits.
  always_comb begin
    km     = RW'(k2);
    km_m1  = km - RW'(1);
    kk_nxt = KW'(km) * KW'(km_m1);
    sk_nxt = SW'(side) * SW'(km);
  end

  logic                  v3_r, nz3_r, inside3_r;
  logic [KW-1:0]         kk3_r;
  logic [SW-1:0]         sk3_r;
  logic [RW-1:0]         step3_r;
  logic [COORD_BITS-1:0] dist3_r;
  logic [1:0]            color3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    nz3_r     <= inside2 && (k2 != '0);
    inside3_r <= inside2;
    kk3_r     <= kk_nxt;
    sk3_r     <= sk_nxt;
    step3_r   <= RW'(step_w);
    dist3_r   <= dist2;
    color3_r  <= color2;
  end

  assign v3      = v3_r;
  assign nz3     = nz3_r;
  assign inside3 = inside3_r;
  assign kk3     = kk3_r;
  assign sk3     = sk3_r;
  assign step3   = step3_r;
  assign dist3   = dist3_r;
  assign color3  = color3_r;

endmodule

`default_nettype wire

// ===== rtl/hxs_index.sv =====
// Last pipeline stage: sums 1 + 3k(k-1) + side*k + step into the spiral index and
// holds the result registers with their strobe. Depends on hxs_pkg for IDX_W.
`default_nettype none

module hxs_index #(
  parameter int COORD_BITS = 11,
  parameter int MAX_RINGS  = 511
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 v3,
  input  wire logic                                 nz3,
  input  wire logic                                 inside3,
  input  wire logic [2*$clog2(MAX_RINGS+1)-1:0]     kk3,
  input  wire logic [$clog2(MAX_RINGS+1)+2:0]       sk3,
  input  wire logic [$clog2(MAX_RINGS+1)-1:0]       step3,
  input  wire logic [COORD_BITS-1:0]                dist3,
  input  wire logic [1:0]                           color3,
  output logic                                      out_valid,
  output logic [hxs_pkg::IDX_W-1:0]                 out_cell_index,
  output logic                                      out_inside_res,
  output logic [COORD_BITS-1:0]                     out_ring_distance,
  output logic [1:0]                                out_tri_color
);
  import hxs_pkg::*;

  localparam int RW = $clog2(MAX_RINGS + 1);
  localparam int IW = 2 * RW + 3;
  localparam int SW = (IW > IDX_W) ? IW : IDX_W;

  logic [SW-1:0]    sum;
  logic [IDX_W-1:0] idx_nxt;

  // Spiral index; cells outside the grid and the centre cell report zero.
  always_comb begin
    sum     = SW'(1) + SW'(kk3) + (SW'(kk3) << 1) + SW'(sk3) + SW'(step3);
    idx_nxt = nz3 ? sum[IDX_W-1:0] : '0;
  end

  logic                  valid_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  inside_r;
  logic [COORD_BITS-1:0] dist_r;
  logic [1:0]            color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    inside_r <= inside3;
    dist_r   <= dist3;
    color_r  <= color3;
  end

  assign out_valid         = valid_r;
  assign out_cell_index    = idx_r;
  assign out_inside_res    = inside_r;
  assign out_ring_distance = dist_r;
  assign out_tri_color     = color_r;

endmodule

`default_nettype wire

// ===== rtl/hex_axial_to_spiral_index_top.sv =====
// Top level of the hex spiral index block: configuration port and four-stage pipeline.
// Depends on hxs_pkg, hxs_cfg, hxs_dist, hxs_side and hxs_index.
//
// Usage:
//   Input channel: drive in_q_coord / in_r_coord and raise start; a beat is taken at
//   every rising edge with start high and busy low. busy stays low, so a new query
//   can be issued in every cycle.
//   Result channel: out_valid marks one result beat for exactly one cycle. Beats come out
//   in query order. Results cannot be held off, and since the pipeline never stalls none
//   is ever dropped.
//   Throughput: one query per cycle. Each query passes through the four register stages
//   in order: magnitudes, distance and grid check, side selection with the k*(k-1)
//   multiply, final index sum.
//   Configuration: ring_count sits at byte address 0 of the APB port, 9 bits, and
//   is clamped to MAX_RINGS when used. Write it only while no query is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and sets ring_count to 4.
`default_nettype none

module hex_axial_to_spiral_index_top #(
  parameter int COORD_BITS = 11,
  parameter int MAX_RINGS  = 511
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [hxs_pkg::CFG_AW-1:0]          paddr,
  input  wire logic [hxs_pkg::CFG_DW-1:0]          pwdata,
  output logic      [hxs_pkg::CFG_DW-1:0]          prdata,
  output logic                                     pready,
  // Query channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_BITS-1:0]        in_q_coord,
  input  wire logic signed [COORD_BITS-1:0]        in_r_coord,
  // Result channel
  output logic                                     out_valid,
  output logic [hxs_pkg::IDX_W-1:0]                out_cell_index,
  output logic                                     out_inside_res,
  output logic [COORD_BITS-1:0]                    out_ring_distance,
  output logic [1:0]                               out_tri_color
);
  import hxs_pkg::*;

  localparam int RW = $clog2(MAX_RINGS + 1);

  logic            in_fire;
  logic [RC_W-1:0] ring_count;

  // The pipeline advances every cycle, so it is never busy.
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  hxs_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ring_count (ring_count)
  );

  // Stage 1 and 2 outputs.
  logic                         v2, inside2;
  logic signed [COORD_BITS+1:0] q2, r2, s2;
  logic [COORD_BITS:0]          k2;
  logic [COORD_BITS-1:0]        dist2;
  logic [1:0]                   color2;

  hxs_dist #(
    .COORD_BITS (COORD_BITS),
    .MAX_RINGS  (MAX_RINGS)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_q       (in_q_coord),
    .in_r       (in_r_coord),
    .ring_count (ring_count),
    .v2         (v2),
    .q2         (q2),
    .r2         (r2),
    .s2         (s2),
    .k2         (k2),
    .inside2    (inside2),
    .dist2      (dist2),
    .color2     (color2)
  );

  // Stage 3 outputs.
  logic                  v3, nz3, inside3;
  logic [2*RW-1:0]       kk3;
  logic [RW+2:0]         sk3;
  logic [RW-1:0]         step3;
  logic [COORD_BITS-1:0] dist3;
  logic [1:0]            color3;

  hxs_side #(
    .COORD_BITS (COORD_BITS),
    .MAX_RINGS  (MAX_RINGS)
  ) u_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .v2      (v2),
    .q2      (q2),
    .r2      (r2),
    .s2      (s2),
    .k2      (k2),
    .inside2 (inside2),
    .dist2   (dist2),
    .color2  (color2),
    .v3      (v3),
    .nz3     (nz3),
    .inside3 (inside3),
    .kk3     (kk3),
    .sk3     (sk3),
    .step3   (step3),
    .dist3   (dist3),
    .color3  (color3)
  );

  hxs_index #(
    .COORD_BITS (COORD_BITS),
    .MAX_RINGS  (MAX_RINGS)
  ) u_index (
    .clk               (clk),
    .rst_n             (rst_n),
    .v3                (v3),
    .nz3               (nz3),
    .inside3           (inside3),
    .kk3               (kk3),
    .sk3               (sk3),
    .step3             (step3),
    .dist3             (dist3),
    .color3            (color3),
    .out_valid         (out_valid),
    .out_cell_index    (out_cell_index),
    .out_inside_res    (out_inside_res),
    .out_ring_distance (out_ring_distance),
    .out_tri_color     (out_tri_color)
  );

endmodule

`default_nettype wire

// ===== bench/hex_axial_to_spiral_index_top_tb.sv =====
// Self-checking testbench for hex_axial_to_spiral_index_top: directed and random hex queries
// are checked beat by beat against a local spiral-index predictor, across ring_count settings.
// Depends on hxs_pkg and the hex_axial_to_spiral_index_top RTL.
module hex_axial_to_spiral_index_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hxs_pkg::*;

  localparam int COORD_BITS   = 11;
  localparam int MAX_RINGS    = 511;
  localparam int PIPE_LATENCY = 4;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_AW-1:0] ADDR_RING_COUNT = {CFG_IDX_RING_COUNT, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED     = {~CFG_IDX_RING_COUNT, 2'b00};

  // Walk direction of each ring side, starting from cell (0, -k).
  localparam int WALK_DQ [6] = '{1, 0, -1, -1, 0, 1};
  localparam int WALK_DR [6] = '{0, 1, 1, 0, -1, -1};

  typedef struct packed {
    logic [IDX_W-1:0]      cell_index;
    logic                  inside_res;
    logic [COORD_BITS-1:0] ring_distance;
    logic [1:0]            tri_color;
  } spiral_result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] q;
    logic [COORD_BITS-1:0] r;
    logic                  known;
    spiral_result_t        want;
  } query_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [CFG_AW-1:0]            paddr;
  logic [CFG_DW-1:0]            pwdata;
  logic [CFG_DW-1:0]            prdata;
  logic                         pready;
  logic                         start;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_q_coord;
  logic signed [COORD_BITS-1:0] in_r_coord;
  logic                         out_valid;
  logic [IDX_W-1:0]             out_cell_index;
  logic                         out_inside_res;
  logic [COORD_BITS-1:0]        out_ring_distance;
  logic [1:0]                   out_tri_color;

  spiral_result_t  pending_results [$];
  query_row_t      directed_rows [$];
  logic [RC_W-1:0] ring_model;
  int              mismatches;

  hex_axial_to_spiral_index_top #(
    .COORD_BITS(COORD_BITS),
    .MAX_RINGS (MAX_RINGS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_q_coord       (in_q_coord),
    .in_r_coord       (in_r_coord),
    .out_valid        (out_valid),
    .out_cell_index   (out_cell_index),
    .out_inside_res   (out_inside_res),
    .out_ring_distance(out_ring_distance),
    .out_tri_color    (out_tri_color)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on run length.
  initial begin
    #2000000;
    $display("FAIL hex_axial_to_spiral_index_top");
    $finish;
  end

  // Spiral index, grid membership, ring and color class of one axial cell.
  function automatic spiral_result_t hex_spiral_predict(input logic [COORD_BITS-1:0] q_bits,
                                                        input logic [COORD_BITS-1:0] r_bits,
                                                        input logic [RC_W-1:0] rings);
    logic signed [COORD_BITS-1:0] qs;
    logic signed [COORD_BITS-1:0] rs;
    int q, r, s, k, lim, step, idx, d;
    side_t side;
    spiral_result_t res;
    qs = q_bits;
    rs = r_bits;
    q = qs;
    r = rs;
    s = -q - r;
    k = (q < 0) ? -q : q;
    if (((r < 0) ? -r : r) > k) k = (r < 0) ? -r : r;
    if (((s < 0) ? -s : s) > k) k = (s < 0) ? -s : s;
    lim = rings;
    if (lim > MAX_RINGS) lim = MAX_RINGS;
    side = SIDE_0;
    step = 0;
    idx  = 0;
    if (k <= lim && k > 0) begin
      if (r == -k && q >= 0 && q < k) begin
        side = SIDE_0; step = q;
      end else if (q == k && r < 0) begin
        side = SIDE_1; step = r + k;
      end else if (s == -k && r >= 0 && r < k) begin
        side = SIDE_2; step = r;
      end else if (r == k && q <= 0 && q > -k) begin
        side = SIDE_3; step = -q;
      end else if (q == -k && r > 0) begin
        side = SIDE_4; step = k - r;
      end else begin
        side = SIDE_5; step = q + k;
      end
      idx = 1 + 3 * k * (k - 1) + int'(side) * k + step;
    end
    d = q - r;
    res.cell_index    = idx[IDX_W-1:0];
    res.inside_res    = (k <= lim);
    res.ring_distance = (k > (1 << COORD_BITS) - 1) ? {COORD_BITS{1'b1}} : k[COORD_BITS-1:0];
    res.tri_color     = 2'(((d % 3) + 3) % 3);
    return res;
  endfunction

  // Count a mismatch and report only the first few.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // One query beat: hold start until accepted, then record what it must produce.
  task automatic send_query(input logic [COORD_BITS-1:0] q, input logic [COORD_BITS-1:0] r,
                            input logic known, input spiral_result_t want);
    in_q_coord <= q;
    in_r_coord <= r;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (known) begin
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(hex_spiral_predict(q, r, ring_model));
    end
  endtask

  // Random gap in the query stream after a burst.
  task automatic query_gap();
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the pipeline drain before touching configuration.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_RING_COUNT) ring_model = data[RC_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read of ring_count, checked against the local copy.
  task automatic check_ring_count();
    logic [CFG_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_RING_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DW'(ring_model)) begin
      report_mismatch($sformatf("ring_count read expected %0d got %0h", ring_model, got));
    end
  endtask

  // Pick a query: mostly ring cells, often at the grid edge; the rest small or random.
  task automatic pick_query(output logic [COORD_BITS-1:0] q, output logic [COORD_BITS-1:0] r);
    int k, side, t, lim, sel, qi, ri;
    int corner_q [6];
    int corner_r [6];
    lim = ring_model;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      q = COORD_BITS'($urandom);
      r = COORD_BITS'($urandom);
    end else if (sel < 35) begin
      qi = int'($urandom_range(0, 24)) - 12;
      ri = int'($urandom_range(0, 24)) - 12;
      q = COORD_BITS'(qi);
      r = COORD_BITS'(ri);
    end else begin
      case ($urandom_range(0, 3))
        0: k = $urandom_range(0, lim + 2);
        1: k = lim;
        2: k = lim + 1;
        default: k = $urandom_range(0, 1023);
      endcase
      if (k > 1023) k = 1023;
      side = $urandom_range(0, 5);
      t = (k == 0) ? 0 : $urandom_range(0, k - 1);
      corner_q = '{0, k, k, 0, -k, -k};
      corner_r = '{-k, -k, 0, k, k, 0};
      qi = corner_q[side] + t * WALK_DQ[side];
      ri = corner_r[side] + t * WALK_DR[side];
      q = COORD_BITS'(qi);
      r = COORD_BITS'(ri);
    end
  endtask

  // Result checker: every strobe beat must match the oldest outstanding query.
  always @(posedge clk) begin : result_check
    spiral_result_t got;
    spiral_result_t want;
    if (rst_n && out_valid) begin
      got = {out_cell_index, out_inside_res, out_ring_distance, out_tri_color};
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no query outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "index exp %0d got %0d, inside exp %0b got %0b, ring exp %0d got %0d, color exp %0d got %0d",
            want.cell_index, got.cell_index, want.inside_res, got.inside_res,
            want.ring_distance, got.ring_distance, want.tri_color, got.tri_color));
        end
      end
    end
  end

  // Main sequence.
  initial begin : main_seq
    int idx, burst, sent, phase;
    logic [COORD_BITS-1:0] q;
    logic [COORD_BITS-1:0] r;
    logic [CFG_DW-1:0] ring_settings [$];
    spiral_result_t none;

    none       = '0;
    mismatches = 0;
    ring_model = RC_RESET;
    rst_n      <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    start      <= 1'b0;
    in_q_coord <= '0;
    in_r_coord <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_ring_count();

    // Directed rows at the reset ring_count of four.
    // Center, first cell of rings one and four, just outside, and the coordinate extremes.
    directed_rows.push_back(query_row_t'{11'(0), 11'(0), 1'b1, spiral_result_t'{20'd0, 1'b1, 11'd0, 2'd0}});
    directed_rows.push_back(query_row_t'{11'(0), 11'(-1), 1'b1, spiral_result_t'{20'd1, 1'b1, 11'd1, 2'd1}});
    directed_rows.push_back(query_row_t'{11'(0), 11'(-4), 1'b1, spiral_result_t'{20'd37, 1'b1, 11'd4, 2'd1}});
    directed_rows.push_back(query_row_t'{11'(0), 11'(-5), 1'b1, spiral_result_t'{20'd0, 1'b0, 11'd5, 2'd2}});
    // Distance saturates only for the most negative corner.
    directed_rows.push_back(query_row_t'{11'(-1024), 11'(-1024), 1'b1,
                                         spiral_result_t'{20'd0, 1'b0, 11'd2047, 2'd0}});
    directed_rows.push_back(query_row_t'{11'(1023), 11'(1023), 1'b1,
                                         spiral_result_t'{20'd0, 1'b0, 11'd2046, 2'd0}});
    directed_rows.push_back(query_row_t'{11'(-1024), 11'(1023), 1'b1,
                                         spiral_result_t'{20'd0, 1'b0, 11'd1024, 2'd2}});
    directed_rows.push_back(query_row_t'{11'(1023), 11'(-1024), 1'b1,
                                         spiral_result_t'{20'd0, 1'b0, 11'd1024, 2'd1}});
    // Both ends of every side of ring two, then a few ring corners and the ring-four tail.
    directed_rows.push_back(query_row_t'{11'(0), 11'(-2), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(1), 11'(-2), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(2), 11'(-2), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(2), 11'(-1), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(2), 11'(0), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(1), 11'(1), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(0), 11'(2), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(-1), 11'(2), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(-2), 11'(2), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(-2), 11'(1), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(-2), 11'(0), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(-1), 11'(-1), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(1), 11'(-1), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(4), 11'(-4), 1'b0, none});
    directed_rows.push_back(query_row_t'{11'(-1), 11'(-3), 1'b0, none});

    idx = 0;
    while (idx < directed_rows.size()) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && idx < directed_rows.size()) begin
        send_query(directed_rows[idx].q, directed_rows[idx].r, directed_rows[idx].known,
                   directed_rows[idx].want);
        idx++;
        burst--;
      end
      query_gap();
    end

    // Random phases, each under its own ring_count; upper data bits must be ignored.
    ring_settings = '{32'd0, 32'd511, 32'd1, 32'hFFFF_FE07, 32'd2, 32'd511, 32'd0};
    ring_settings[4] = $urandom_range(3, 510);
    ring_settings[6] = $urandom | 32'(1 << RC_W);
    for (phase = 0; phase < ring_settings.size(); phase++) begin
      drain_pipeline();
      if (phase == 3) begin
        // A write to an unmapped word must leave ring_count alone.
        cfg_write(ADDR_UNUSED, $urandom);
        check_ring_count();
      end
      cfg_write(ADDR_RING_COUNT, ring_settings[phase]);
      check_ring_count();
      sent = 0;
      while (sent < PHASE_ITEMS && phase * PHASE_ITEMS + sent < RANDOM_ITEMS) begin
        burst = $urandom_range(1, 40);
        while (burst > 0 && sent < PHASE_ITEMS) begin
          pick_query(q, r);
          send_query(q, r, 1'b0, none);
          sent++;
          burst--;
        end
        query_gap();
      end
    end

    // Drain and decide.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS hex_axial_to_spiral_index_top");
    end else begin
      $display("FAIL hex_axial_to_spiral_index_top");
    end
    $finish;
  end

endmodule
